FILE: src/cbw_pkg.sv
// package with widths, constants and pipeline types for the barycentric weight core
`timescale 1ns / 1ps
package cbw_pkg;
	localparam int COORD_W = 24;
	localparam int N_FIELDS = 12;
	localparam int IN_DATA_W = COORD_W * N_FIELDS;
	localparam int WGT_W = 24;
	localparam int OUT_DATA_W = 3 * WGT_W;
	localparam int THRESH_W = 63;
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(33554432);
	localparam int W_FRAC = 16;

	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DOT_W = PROD_W + 2;
	localparam int HALF_W = DOT_W / 2;
	localparam int PP_W = 2 * (HALF_W + 1);
	localparam int WIDE_W = 2 * DOT_W;
	localparam int DET_W = WIDE_W + 1;
	localparam int NUM1_W = DET_W + W_FRAC;
	localparam int Q_W = WGT_W - 1;
	localparam int DIV1_W = 128;
	localparam int PM_W = HALF_W + 1 + WGT_W + 1;
	localparam int NUM2_W = 77;
	localparam int DIV2_W = 80;
	localparam int W3_W = WGT_W + 2;

	localparam logic [WGT_W-1:0] W_MAX = {1'b0, {(WGT_W-1){1'b1}}};
	localparam logic [WGT_W-1:0] W_MIN = {1'b1, {(WGT_W-1){1'b0}}};
	localparam logic [WGT_W-1:0] ONE_THIRD = WGT_W'((1 << W_FRAC) / 3);
	localparam logic signed [W3_W-1:0] W3_ONE = W3_W'(1 << W_FRAC);

	localparam int N_STAGES = 7 + Q_W + 4 + Q_W + 1;

	typedef struct packed {
		logic [DIV1_W-1:0] rem;
		logic [DET_W-2:0] dvs;
		logic [Q_W-1:0] q;
		logic signed [DOT_W-1:0] b;
		logic signed [DOT_W-1:0] c;
		logic signed [DOT_W-1:0] f;
		logic degen;
		logic neg;
		logic sat;
	} div1_t;

	typedef struct packed {
		logic [DIV2_W-1:0] rem;
		logic [DOT_W-2:0] dvs;
		logic [Q_W-1:0] q;
		logic [WGT_W-1:0] w1;
		logic degen;
		logic neg;
		logic sat;
	} div2_t;
endpackage

FILE: src/clamped_barycentric_weights_core.sv
// clamped barycentric weights of a point against a triangle, fully pipelined
// throughput: one request per cycle unless the output stalls; each weight divider resolves one quotient bit per stage
// output stalls freeze the whole pipeline, so nothing is lost or repeated
// reset clears all valid bits and loads the default threshold
`timescale 1ns / 1ps
module clamped_barycentric_weights_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point x,y,z, corner a x,y,z, corner b x,y,z, corner c x,y,z
	input  logic [cbw_pkg::IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// weight_a, weight_b, weight_c
	output logic [cbw_pkg::OUT_DATA_W-1:0] m_tdata,
	// degenerate
	output logic m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cbw_pkg::THRESH_W-1:0] cfg_data
);
	import cbw_pkg::*;

	function automatic logic signed [HALF_W:0] hi_part(input logic signed [DOT_W-1:0] x);
		return $signed({x[DOT_W-1], x[DOT_W-1:HALF_W]});
	endfunction

	function automatic logic signed [HALF_W:0] lo_part(input logic signed [DOT_W-1:0] x);
		return $signed({1'b0, x[HALF_W-1:0]});
	endfunction

	function automatic logic signed [WIDE_W-1:0] combine(input logic signed [PP_W-1:0] ll,
			input logic signed [PP_W-1:0] lh, input logic signed [PP_W-1:0] hl,
			input logic signed [PP_W-1:0] hh);
		return (WIDE_W'(hh) <<< (2 * HALF_W)) + ((WIDE_W'(lh) + WIDE_W'(hl)) <<< HALF_W)
			+ WIDE_W'(ll);
	endfunction

	logic en;
	logic [N_STAGES-1:0] vld_q;
	logic [THRESH_W-1:0] thr_q;

	assign en = !vld_q[N_STAGES-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[N_STAGES-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= THRESH_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[N_STAGES-2:0], s_tvalid};
			end
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
		end
	end

	logic signed [COORD_W-1:0] fld [N_FIELDS];
	always_comb begin
		for (int i = 0; i < N_FIELDS; i++) begin
			fld[i] = $signed(s_tdata[i*COORD_W +: COORD_W]);
		end
	end

	// edge vectors relative to corner c
	logic signed [DIFF_W-1:0] u_s1 [3];
	logic signed [DIFF_W-1:0] v_s1 [3];
	logic signed [DIFF_W-1:0] t_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				u_s1[j] <= DIFF_W'(fld[3+j]) - DIFF_W'(fld[9+j]);
				v_s1[j] <= DIFF_W'(fld[6+j]) - DIFF_W'(fld[9+j]);
				t_s1[j] <= DIFF_W'(fld[j]) - DIFF_W'(fld[9+j]);
			end
		end
	end

	logic signed [PROD_W-1:0] p_s2 [15];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				p_s2[j]      <= u_s1[j] * u_s1[j];
				p_s2[3+j]  <= u_s1[j] * v_s1[j];
				p_s2[6+j]  <= v_s1[j] * v_s1[j];
				p_s2[9+j]  <= u_s1[j] * t_s1[j];
				p_s2[12+j] <= v_s1[j] * t_s1[j];
			end
		end
	end

	logic signed [DOT_W-1:0] dot_s3 [5];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 5; k++) begin
				dot_s3[k] <= DOT_W'(p_s2[3*k]) + DOT_W'(p_s2[3*k+1]) + DOT_W'(p_s2[3*k+2]);
			end
		end
	end

	// dot_s3: a, b, c, e, f
	logic signed [DOT_W-1:0] ma [4];
	logic signed [DOT_W-1:0] mb [4];
	assign ma[0] = dot_s3[0];
	assign mb[0] = dot_s3[2];
	assign ma[1] = dot_s3[1];
	assign mb[1] = dot_s3[1];
	assign ma[2] = dot_s3[3];
	assign mb[2] = dot_s3[2];
	assign ma[3] = dot_s3[1];
	assign mb[3] = dot_s3[4];

	logic signed [PP_W-1:0] pp_s4 [16];
	logic signed [DOT_W-1:0] b_s4, c_s4, f_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				pp_s4[4*m]   <= lo_part(ma[m]) * lo_part(mb[m]);
				pp_s4[4*m+1] <= lo_part(ma[m]) * hi_part(mb[m]);
				pp_s4[4*m+2] <= hi_part(ma[m]) * lo_part(mb[m]);
				pp_s4[4*m+3] <= hi_part(ma[m]) * hi_part(mb[m]);
			end
			b_s4 <= dot_s3[1];
			c_s4 <= dot_s3[2];
			f_s4 <= dot_s3[4];
		end
	end

	// wide_s5: a*c, b*b, e*c, b*f
	logic signed [WIDE_W-1:0] wide_s5 [4];
	logic signed [DOT_W-1:0] b_s5, c_s5, f_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				wide_s5[m] <= combine(pp_s4[4*m], pp_s4[4*m+1], pp_s4[4*m+2], pp_s4[4*m+3]);
			end
			b_s5 <= b_s4;
			c_s5 <= c_s4;
			f_s5 <= f_s4;
		end
	end

	logic signed [DET_W-1:0] d_s6;
	logic signed [NUM1_W-1:0] n1_s6;
	logic signed [DOT_W-1:0] b_s6, c_s6, f_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s6 <= DET_W'(wide_s5[0]) - DET_W'(wide_s5[1]);
			n1_s6 <= (NUM1_W'(wide_s5[2]) - NUM1_W'(wide_s5[3])) <<< W_FRAC;
			b_s6 <= b_s5;
			c_s6 <= c_s5;
			f_s6 <= f_s5;
		end
	end

	div1_t dv1_s [Q_W+1];
	div1_t ld1;
	div1_t nx1 [Q_W];
	logic [DIV1_W-1:0] sh1 [Q_W];
	logic ge1 [Q_W];

	always_comb begin
		ld1.rem = DIV1_W'(n1_s6[NUM1_W-2:0]);
		ld1.dvs = d_s6[DET_W-2:0];
		ld1.q = '0;
		ld1.b = b_s6;
		ld1.c = c_s6;
		ld1.f = f_s6;
		ld1.degen = d_s6[DET_W-1] || (d_s6 == '0)
			|| (d_s6[DET_W-2:0] < (DET_W-1)'(thr_q));
		ld1.neg = n1_s6[NUM1_W-1];
		ld1.sat = DIV1_W'(n1_s6[NUM1_W-2:0])
			>= (DIV1_W'(d_s6[DET_W-2:0]) << Q_W);
	end

	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			sh1[i] = DIV1_W'(dv1_s[i].dvs) << (Q_W - 1 - i);
			ge1[i] = dv1_s[i].rem >= sh1[i];
			nx1[i] = dv1_s[i];
			if (ge1[i]) begin
				nx1[i].rem = dv1_s[i].rem - sh1[i];
				nx1[i].q[Q_W-1-i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv1_s[0] <= ld1;
			for (int i = 0; i < Q_W; i++) begin
				dv1_s[i+1] <= nx1[i];
			end
		end
	end

	logic [WGT_W-1:0] w1_s31;
	logic signed [DOT_W-1:0] b_s31, c_s31, f_s31;
	logic degen_s31;
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (dv1_s[Q_W].neg) begin
				w1_s31 <= '0;
			end else if (dv1_s[Q_W].sat) begin
				w1_s31 <= W_MAX;
			end else begin
				w1_s31 <= WGT_W'(dv1_s[Q_W].q);
			end
			b_s31 <= dv1_s[Q_W].b;
			c_s31 <= dv1_s[Q_W].c;
			f_s31 <= dv1_s[Q_W].f;
			degen_s31 <= dv1_s[Q_W].degen;
		end
	end

	logic signed [PM_W-1:0] pm_hi_s32, pm_lo_s32;
	logic [WGT_W-1:0] w1_s32;
	logic signed [DOT_W-1:0] c_s32, f_s32;
	logic degen_s32;
	always_ff @(posedge clk) begin
		if (en) begin
			pm_hi_s32 <= hi_part(b_s31) * $signed({1'b0, w1_s31});
			pm_lo_s32 <= lo_part(b_s31) * $signed({1'b0, w1_s31});
			w1_s32 <= w1_s31;
			c_s32 <= c_s31;
			f_s32 <= f_s31;
			degen_s32 <= degen_s31;
		end
	end

	logic signed [NUM2_W-1:0] n2_s33;
	logic [WGT_W-1:0] w1_s33;
	logic signed [DOT_W-1:0] c_s33;
	logic degen_s33;
	always_ff @(posedge clk) begin
		if (en) begin
			n2_s33 <= (NUM2_W'(f_s32) <<< W_FRAC)
				- ((NUM2_W'(pm_hi_s32) <<< HALF_W) + NUM2_W'(pm_lo_s32));
			w1_s33 <= w1_s32;
			c_s33 <= c_s32;
			degen_s33 <= degen_s32;
		end
	end

	div2_t dv2_s [Q_W+1];
	div2_t ld2;
	div2_t nx2 [Q_W];
	logic [DIV2_W-1:0] sh2 [Q_W];
	logic ge2 [Q_W];

	always_comb begin
		ld2.rem = DIV2_W'(n2_s33[NUM2_W-2:0]);
		ld2.dvs = c_s33[DOT_W-2:0];
		ld2.q = '0;
		ld2.w1 = w1_s33;
		ld2.degen = degen_s33;
		ld2.neg = n2_s33[NUM2_W-1];
		ld2.sat = DIV2_W'(n2_s33[NUM2_W-2:0]) >= (DIV2_W'(c_s33[DOT_W-2:0]) << Q_W);
	end

	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			sh2[i] = DIV2_W'(dv2_s[i].dvs) << (Q_W - 1 - i);
			ge2[i] = dv2_s[i].rem >= sh2[i];
			nx2[i] = dv2_s[i];
			if (ge2[i]) begin
				nx2[i].rem = dv2_s[i].rem - sh2[i];
				nx2[i].q[Q_W-1-i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv2_s[0] <= ld2;
			for (int i = 0; i < Q_W; i++) begin
				dv2_s[i+1] <= nx2[i];
			end
		end
	end

	logic [WGT_W-1:0] w2_c;
	logic signed [W3_W-1:0] w3_c;
	logic [WGT_W-1:0] w3_sat;
	always_comb begin
		priority if (dv2_s[Q_W].neg) begin
			w2_c = '0;
		end else if (dv2_s[Q_W].sat) begin
			w2_c = W_MAX;
		end else begin
			w2_c = WGT_W'(dv2_s[Q_W].q);
		end
		w3_c = W3_ONE - $signed(W3_W'(dv2_s[Q_W].w1)) - $signed(W3_W'(w2_c));
		priority if (w3_c > $signed(W3_W'($signed(W_MAX)))) begin
			w3_sat = W_MAX;
		end else if (w3_c < $signed(W3_W'($signed(W_MIN)))) begin
			w3_sat = W_MIN;
		end else begin
			w3_sat = w3_c[WGT_W-1:0];
		end
	end

	logic [WGT_W-1:0] wa_s58, wb_s58, wc_s58;
	logic degen_s58;
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv2_s[Q_W].degen) begin
				wa_s58 <= ONE_THIRD;
				wb_s58 <= ONE_THIRD;
				wc_s58 <= ONE_THIRD;
			end else begin
				wa_s58 <= dv2_s[Q_W].w1;
				wb_s58 <= w2_c;
				wc_s58 <= w3_sat;
			end
			degen_s58 <= dv2_s[Q_W].degen;
		end
	end

	assign m_tdata = {wc_s58, wb_s58, wa_s58};
	assign m_tuser = degen_s58;

	a_degen_third: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> wa_s58 == ONE_THIRD && wb_s58 == ONE_THIRD
			&& wc_s58 == ONE_THIRD)
		else $error("degenerate result without one-third weights");
	a_clamped_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !wa_s58[WGT_W-1] && !wb_s58[WGT_W-1])
		else $error("clamped weight is negative");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("pipeline stalled with free output");
	a_w1_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[30] |-> !w1_s31[WGT_W-1])
		else $error("first weight out of clamp range");
endmodule

FILE: tb/clamped_barycentric_weights_core_tb.sv
// testbench for the clamped barycentric weight core: random and directed requests, scoreboard check
`timescale 1ns / 1ps
module clamped_barycentric_weights_core_tb;
	import cbw_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [WGT_W-1:0] wa;
		logic [WGT_W-1:0] wb;
		logic [WGT_W-1:0] wc;
		logic degen;
	} weights_t;

	class weight_scoreboard;
		logic [THRESH_W-1:0] threshold;
		weights_t pending_q[$];
		int n_requests;
		int n_results;
		int n_degen;
		int n_mismatch;

		function new();
			threshold = THRESH_RESET;
			n_requests = 0;
			n_results = 0;
			n_degen = 0;
			n_mismatch = 0;
		endfunction

		function automatic wide_t clamp_quot(wide_t num, wide_t den);
			wide_t q;
			if (num < 0)
				return 0;
			q = num / den;
			if (q > 128'sd8388607)
				return 128'sd8388607;
			return q;
		endfunction

		function automatic weights_t weigh(logic [IN_DATA_W-1:0] data);
			longint u[3], v[3], t[3];
			longint cc;
			wide_t a, b, c, e, f, d, n1, n2, w1, w2;
			longint w3;
			weights_t r;
			for (int i = 0; i < 3; i++) begin
				cc = longint'(coord_t'(data[(9 + i) * COORD_W +: COORD_W]));
				u[i] = longint'(coord_t'(data[(3 + i) * COORD_W +: COORD_W])) - cc;
				v[i] = longint'(coord_t'(data[(6 + i) * COORD_W +: COORD_W])) - cc;
				t[i] = longint'(coord_t'(data[i * COORD_W +: COORD_W])) - cc;
			end
			a = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
			b = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
			c = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
			e = u[0] * t[0] + u[1] * t[1] + u[2] * t[2];
			f = v[0] * t[0] + v[1] * t[1] + v[2] * t[2];
			d = a * c - b * b;
			r.degen = (d <= 0) || (d < $signed({65'b0, threshold}));
			if (r.degen) begin
				r.wa = ONE_THIRD;
				r.wb = ONE_THIRD;
				r.wc = ONE_THIRD;
			end else begin
				n1 = (e * c - b * f) <<< W_FRAC;
				w1 = clamp_quot(n1, d);
				n2 = (f <<< W_FRAC) - b * w1;
				w2 = clamp_quot(n2, c);
				w3 = (longint'(1) << W_FRAC) - longint'(w1) - longint'(w2);
				if (w3 > 8388607)
					w3 = 8388607;
				if (w3 < -8388608)
					w3 = -8388608;
				r.wa = w1[WGT_W-1:0];
				r.wb = w2[WGT_W-1:0];
				r.wc = w3[WGT_W-1:0];
			end
			return r;
		endfunction

		function void note_request(logic [IN_DATA_W-1:0] data);
			weights_t r;
			r = weigh(data);
			pending_q.push_back(r);
			n_requests++;
			if (r.degen)
				n_degen++;
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic degen);
			weights_t x;
			n_results++;
			if (pending_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result %h degen %b", data, degen);
				return;
			end
			x = pending_q.pop_front();
			if (data !== {x.wc, x.wb, x.wa} || degen !== x.degen) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("mismatch: expected a=%h b=%h c=%h degen=%b, got a=%h b=%h c=%h degen=%b",
						x.wa, x.wb, x.wc, x.degen, data[WGT_W-1:0], data[2*WGT_W-1:WGT_W],
						data[3*WGT_W-1:2*WGT_W], degen);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [THRESH_W-1:0] cfg_data;

	weight_scoreboard sb;
	bit quiet;
	bit hold_req;
	int stall_cnt = 0;

	clamped_barycentric_weights_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send(coord_t p[3], coord_t ca[3], coord_t cb[3], coord_t cc[3]);
		logic [IN_DATA_W-1:0] d;
		for (int i = 0; i < 3; i++) begin
			d[i * COORD_W +: COORD_W] = p[i];
			d[(3 + i) * COORD_W +: COORD_W] = ca[i];
			d[(6 + i) * COORD_W +: COORD_W] = cb[i];
			d[(9 + i) * COORD_W +: COORD_W] = cc[i];
		end
		if (!quiet && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_threshold(logic [THRESH_W-1:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.threshold = value;
	endtask

	task automatic send_random();
		coord_t p[3], ca[3], cb[3], cc[3];
		int k, mode;
		mode = $urandom_range(99);
		k = $urandom_range(0, 19);
		for (int i = 0; i < 3; i++) begin
			if (mode < 30) begin
				p[i] = coord_t'($urandom);
				ca[i] = coord_t'($urandom);
				cb[i] = coord_t'($urandom);
				cc[i] = coord_t'($urandom);
			end else if (mode < 85) begin
				cc[i] = coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
				ca[i] = coord_t'(cc[i] + $signed($urandom_range(0, 2 << k)) - (1 << k));
				cb[i] = coord_t'(cc[i] + $signed($urandom_range(0, 2 << k)) - (1 << k));
				p[i] = coord_t'(cc[i] + $signed($urandom_range(0, 4 << k)) - (2 << k));
			end else begin
				// collinear or coincident corners
				cc[i] = coord_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
				ca[i] = coord_t'(cc[i] + $signed($urandom_range(0, 2 << k)) - (1 << k));
				cb[i] = (mode < 92) ? coord_t'(cc[i] + 2 * (ca[i] - cc[i])) : ca[i];
				if ($urandom_range(3) == 0)
					cb[i] = coord_t'(cb[i] + $signed($urandom_range(0, 2)) - 1);
				p[i] = coord_t'(cc[i] + $signed($urandom_range(0, 2 << k)) - (1 << k));
			end
		end
		send(p, ca, cb, cc);
	endtask

	task automatic send_directed();
		coord_t z[3], mx[3], mn[3], ca[3], cb[3], cc[3];
		z = '{0, 0, 0};
		mx = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
		mn = '{24'sh800000, 24'sh800000, 24'sh800000};
		send(z, z, z, z);
		send(mx, mx, mx, mx);
		send(mn, mn, mn, mn);
		send(mx, mx, mn, z);
		send(mn, '{24'sh7fffff, 24'sh800000, 0}, '{24'sh800000, 24'sh7fffff, 24'sh7fffff}, mn);
		send(mx, '{24'sh7fffff, 24'sh800000, 0}, '{0, 24'sh7fffff, 24'sh800000}, mn);
		ca = '{4096, 0, 0};
		cb = '{0, 4096, 0};
		cc = '{0, 0, 0};
		// centroid, corners, outside on each side
		send('{1365, 1365, 0}, ca, cb, cc);
		send(ca, ca, cb, cc);
		send(cb, ca, cb, cc);
		send(cc, ca, cb, cc);
		send('{-4096, 2048, 100}, ca, cb, cc);
		send('{2048, -4096, -100}, ca, cb, cc);
		send('{8192, 8192, 0}, ca, cb, cc);
		// tiny triangle with a far point saturates the weights
		ca = '{64, 0, 0};
		cb = '{0, 64, 0};
		send('{24'sh7fffff, 24'sh7fffff, 0}, ca, cb, cc);
		send('{24'sh7fffff, 0, 0}, ca, cb, cc);
		send('{24'sh800000, 24'sh800000, 0}, ca, cb, cc);
		// small determinant below the default limit
		send('{3, 3, 0}, '{8, 0, 0}, '{0, 8, 0}, cc);
		// collinear corners
		send('{5, 7, 9}, '{100, 200, 300}, '{200, 400, 600}, cc);
		send('{1, 2, 3}, '{5, 5, 5}, '{5, 5, 5}, '{1, 1, 1});
	endtask

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= 20000) begin
			$display("watchdog: no progress for %0d cycles", stall_cnt);
			$display("[clamped_barycentric_weights_core] ERROR");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= quiet || $urandom_range(99) >= 13;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [THRESH_W-1:0] thr_list[5];
		sb = new();
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		thr_list = '{'0, {THRESH_W{1'b1}}, THRESH_RESET, 63'd1 << 40, 63'd1 << 60};
		foreach (thr_list[ph]) begin
			write_threshold(thr_list[ph]);
			send_directed();
			if (ph == 0)
				hold_req = 1'b1;
			for (int n = 0; n < 400; n++) begin
				quiet = (ph == 2) && n >= 100 && n < 300;
				send_random();
			end
			quiet = 1'b0;
		end
		write_threshold(THRESH_W'($urandom_range(0, 1 << 30)));
		for (int n = 0; n < 100; n++)
			send_random();
		s_tvalid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("covered %0d requests and %0d results, %0d degenerate, over six thresholds",
			sb.n_requests, sb.n_results, sb.n_degen);
		$display("mismatches: %0d", sb.n_mismatch);
		if (sb.n_mismatch == 0 && sb.pending_q.size() == 0)
			$display("[clamped_barycentric_weights_core] OK");
		else
			$display("[clamped_barycentric_weights_core] ERROR");
		$finish;
	end
endmodule

FILE: filelist.f
src/cbw_pkg.sv
src/clamped_barycentric_weights_core.sv
tb/clamped_barycentric_weights_core_tb.sv
